>>> hw/rtl/adtt_pkg.sv
// ----------------------------------------------------------------------------
// Active decode target tracker package
// Shared types, register indexes, limits and mask helpers.
// ----------------------------------------------------------------------------
package adtt_pkg;

  localparam int MAX_TARGETS = 8;
  localparam int MAX_CHAINS  = 8;
  localparam int MASK_W      = 8;
  localparam int FRAME_W     = 16;
  localparam int DELTA_W     = 8;
  localparam int IDX_W       = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [MASK_W-1:0] FORCED_CHAIN_MASK = 8'h02;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_TARGETS      = 2'd0,
    CFG_NUM_CHAIN_COUNT  = 2'd1,
    CFG_TARGET_CHAIN_MAP = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [IDX_W-1:0]            num_targets;
    logic [IDX_W-1:0]            num_chain_count;
    logic [MASK_W*IDX_W-1:0]     target_chain_map;
  } cfg_t;

  typedef struct packed {
    logic [FRAME_W-1:0] prev_frame_number;
    logic [MASK_W-1:0]  prev_targets;
    logic [MASK_W-1:0]  live_chains;
    logic [MASK_W-1:0]  unsent_chains;
  } state_t;

  typedef struct packed {
    logic [MASK_W-1:0]         active_targets;
    logic                      key_frame;
    logic [FRAME_W-1:0]        frame_number;
    logic [MASK_W*DELTA_W-1:0] chain_deltas;
  } item_t;

  typedef struct packed {
    logic [MASK_W-1:0] current_targets;
    logic [MASK_W-1:0] current_chains;
    logic [MASK_W-1:0] pending_chains;
    logic              targets_changed;
  } result_t;

  // Limits a configured count to the structure limit and to the mask width.
  function automatic logic [IDX_W-1:0] clamp_count(input logic [IDX_W-1:0] n,
                                                   input int limit);
    logic [IDX_W-1:0] c;
    c = n;
    if (int'(c) > limit) c = IDX_W'(limit);
    if (int'(c) > MASK_W) c = IDX_W'(MASK_W);
    return c;
  endfunction

  // Mask with the low n bits set; zero gives an empty mask.
  function automatic logic [MASK_W-1:0] low_mask(input logic [IDX_W-1:0] n);
    logic [MASK_W-1:0] m;
    for (int i = 0; i < MASK_W; i++) begin
      m[i] = (IDX_W'(i) < n);
    end
    return m;
  endfunction

endpackage

>>> hw/rtl/adtt_cfg_regs.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the target count, chain count and target-to-chain map.
// ----------------------------------------------------------------------------
module adtt_cfg_regs
  import adtt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_reg_e'(cfg_index))
        CFG_NUM_TARGETS:      cfg_nxt.num_targets      = cfg_data[IDX_W-1:0];
        CFG_NUM_CHAIN_COUNT:  cfg_nxt.num_chain_count  = cfg_data[IDX_W-1:0];
        CFG_TARGET_CHAIN_MAP: cfg_nxt.target_chain_map = cfg_data[MASK_W*IDX_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> hw/rtl/adtt_core.sv
// ----------------------------------------------------------------------------
// Tracker update logic
// Computes the next tracker state and the result for one frame.
// ----------------------------------------------------------------------------
module adtt_core
  import adtt_pkg::*;
#(
  parameter int TARGET_LIMIT = MAX_TARGETS,
  parameter int CHAIN_LIMIT  = MAX_CHAINS
)
(
  input  cfg_t    cfg,
  input  state_t  st,
  input  item_t   item,
  output state_t  st_next,
  output result_t res
);

  logic [IDX_W-1:0]   nt;
  logic [IDX_W-1:0]   nc;
  logic [MASK_W-1:0]  all_targets;
  logic [MASK_W-1:0]  all_chains;
  logic [MASK_W-1:0]  req;
  logic [FRAME_W-1:0] diff;
  logic [MASK_W-1:0]  sent;
  logic [MASK_W-1:0]  chains;
  logic [MASK_W-1:0]  base_targets;
  logic [MASK_W-1:0]  base_live;
  logic [MASK_W-1:0]  base_unsent;
  logic [IDX_W-1:0]   idx;
  logic               changed;

  assign nt          = clamp_count(cfg.num_targets, TARGET_LIMIT);
  assign nc          = clamp_count(cfg.num_chain_count, CHAIN_LIMIT);
  assign all_targets = low_mask(nt);
  assign all_chains  = low_mask(nc);
  assign req         = item.active_targets & all_targets;
  assign diff        = item.frame_number - st.prev_frame_number;

  always_comb begin
    sent   = '0;
    chains = '0;
    idx    = '0;
    for (int i = 0; i < MASK_W; i++) begin
      sent[i] = all_chains[i] && (diff[FRAME_W-1:DELTA_W] == '0) &&
                (item.chain_deltas[DELTA_W*i +: DELTA_W] == diff[DELTA_W-1:0]);
    end
    for (int i = 0; i < MASK_W; i++) begin
      idx = cfg.target_chain_map[IDX_W*i +: IDX_W];
      if (req[i] && (idx < nc)) begin
        chains[idx[2:0]] = 1'b1;
      end
    end
  end

  always_comb begin
    if (item.key_frame) begin
      base_targets = all_targets;
      base_live    = all_chains;
      base_unsent  = '0;
    end else begin
      base_targets = st.prev_targets;
      base_live    = st.live_chains;
      base_unsent  = st.unsent_chains & ~sent;
    end
  end

  assign changed = (req != base_targets);

  always_comb begin
    st_next.prev_frame_number = item.frame_number;
    if (changed) begin
      st_next.prev_targets  = req;
      st_next.live_chains   = chains;
      st_next.unsent_chains = (chains == '0) ? FORCED_CHAIN_MASK : chains;
    end else begin
      st_next.prev_targets  = base_targets;
      st_next.live_chains   = base_live;
      st_next.unsent_chains = base_unsent;
    end
  end

  assign res.current_targets = st_next.prev_targets;
  assign res.current_chains  = st_next.live_chains;
  assign res.pending_chains  = st_next.unsent_chains;
  assign res.targets_changed = changed;

endmodule

>>> hw/rtl/active_decode_target_tracker_unit.sv
// ----------------------------------------------------------------------------
// Active decode target tracker
// Tracks active decode targets and chains across video frames.
// ----------------------------------------------------------------------------
// One request per frame enters on the in_ channel (in_valid / in_stall) and
// is taken at an edge with in_valid high and in_stall low. It is captured in
// an input register; once the output register is free, the frame is applied to
// the tracker state and its result is loaded into the output register and
// shown on the out_ channel. A new request can be taken in every cycle while
// out_stall is low, giving one frame per cycle sustained; the limit is the
// single state update per cycle in the tracker logic.
// When the receiver holds out_stall, the result stays on the outputs, the
// waiting request stays in the input register and in_stall rises only once
// both registers are full.
// Configuration writes on the cfg_ channel are always ready and must be made
// while no frame is in flight.
// Synchronous reset clears the configuration, the tracker state and both
// valid flags.
// ----------------------------------------------------------------------------
module active_decode_target_tracker_unit
  import adtt_pkg::*;
#(
  parameter int TARGET_LIMIT = MAX_TARGETS,
  parameter int CHAIN_LIMIT  = MAX_CHAINS
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [MASK_W-1:0]     in_active_targets,
  input  logic                  in_key_frame,
  input  logic [FRAME_W-1:0]    in_frame_number,
  input  logic [63:0]           in_chain_deltas,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [MASK_W-1:0]     out_current_targets,
  output logic [MASK_W-1:0]     out_current_chains,
  output logic [MASK_W-1:0]     out_pending_chains,
  output logic                  out_targets_changed
);

  cfg_t    cfg;
  state_t  st_r;
  state_t  st_next;
  item_t   item_r;
  result_t res;
  result_t res_r;
  logic    item_valid_r;
  logic    out_valid_r;
  logic    out_free;
  logic    advance;
  logic    in_take;

  assign cfg_ready = 1'b1;

  adtt_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  adtt_core #(
    .TARGET_LIMIT (TARGET_LIMIT),
    .CHAIN_LIMIT  (CHAIN_LIMIT)
  ) u_core (
    .cfg     (cfg),
    .st      (st_r),
    .item    (item_r),
    .st_next (st_next),
    .res     (res)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign advance  = item_valid_r && out_free;
  assign in_stall = item_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      st_r         <= '0;
    end else begin
      if (in_take) begin
        item_valid_r <= 1'b1;
      end else if (advance) begin
        item_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        st_r        <= st_next;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.active_targets <= in_active_targets;
      item_r.key_frame      <= in_key_frame;
      item_r.frame_number   <= in_frame_number;
      item_r.chain_deltas   <= in_chain_deltas;
    end
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_current_targets = res_r.current_targets;
  assign out_current_chains  = res_r.current_chains;
  assign out_pending_chains  = res_r.pending_chains;
  assign out_targets_changed = res_r.targets_changed;

endmodule

>>> hw/rtl/adtt_checker.sv
// ----------------------------------------------------------------------------
// Tracker port checker
// Checks reset, output hold and chain mask relations at the top level ports.
// ----------------------------------------------------------------------------
module adtt_checker
  import adtt_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic [MASK_W-1:0] out_current_targets,
  input logic [MASK_W-1:0] out_current_chains,
  input logic [MASK_W-1:0] out_pending_chains,
  input logic              out_targets_changed
);

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pending_chains) &&
                               $stable(out_current_chains) &&
                               $stable(out_current_targets) &&
                               $stable(out_targets_changed))
    else $error("stalled result changed");

  a_pending_in_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pending_chains & ~(out_current_chains | FORCED_CHAIN_MASK)) == '0)
    else $error("pending chain outside the active chains");

  a_change_resets_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_targets_changed |->
      (out_pending_chains == out_current_chains) ||
      (out_current_chains == '0 && out_pending_chains == FORCED_CHAIN_MASK))
    else $error("pending chains not reloaded on a target change");

endmodule

bind active_decode_target_tracker_unit adtt_checker u_adtt_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_current_targets (out_current_targets),
  .out_current_chains  (out_current_chains),
  .out_pending_chains  (out_pending_chains),
  .out_targets_changed (out_targets_changed)
);

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Active decode target tracker testbench
// Drives frame requests and structure register writes into the tracker with
// random idling on both channels, predicts every frame's target and chain
// masks from a mirror of the tracker state, and checks each result in order.
// ----------------------------------------------------------------------------
module tb;
  import adtt_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  class chain_mask_scoreboard;
    cfg_t    structure;
    state_t  tracker;
    result_t expected_masks[$];
    int      errors;

    function new();
      structure = '0;
      tracker = '0;
      errors = 0;
    endfunction

    function logic [IDX_W-1:0] sat_count(input logic [IDX_W-1:0] n);
      return (n > IDX_W'(MASK_W)) ? IDX_W'(MASK_W) : n;
    endfunction

    function logic [MASK_W-1:0] ones_below(input logic [IDX_W-1:0] n);
      logic [MASK_W-1:0] m;
      for (int i = 0; i < MASK_W; i++) begin
        m[i] = (i < n);
      end
      return m;
    endfunction

    function void note_config(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_NUM_TARGETS: begin
          structure.num_targets = data[IDX_W-1:0];
        end
        CFG_NUM_CHAIN_COUNT: begin
          structure.num_chain_count = data[IDX_W-1:0];
        end
        CFG_TARGET_CHAIN_MAP: begin
          structure.target_chain_map = data;
        end
        default: begin
        end
      endcase
    endfunction

    function void note_request(input item_t it);
      logic [IDX_W-1:0]   nt;
      logic [IDX_W-1:0]   nc;
      logic [IDX_W-1:0]   idx;
      logic [MASK_W-1:0]  all_targets;
      logic [MASK_W-1:0]  req;
      logic [MASK_W-1:0]  sent;
      logic [MASK_W-1:0]  chains;
      logic [FRAME_W-1:0] diff;
      result_t            r;
      int                 c;
      nt = sat_count(structure.num_targets);
      nc = sat_count(structure.num_chain_count);
      all_targets = ones_below(nt);
      req = it.active_targets & all_targets;
      r.targets_changed = 1'b0;
      if (it.key_frame) begin
        tracker.prev_targets = all_targets;
        tracker.live_chains = ones_below(nc);
        tracker.unsent_chains = '0;
      end else begin
        diff = it.frame_number - tracker.prev_frame_number;
        sent = '0;
        for (c = 0; c < MASK_W; c++) begin
          if (c < nc && {8'h00, it.chain_deltas[DELTA_W*c +: DELTA_W]} == diff) begin
            sent[c] = 1'b1;
          end
        end
        tracker.unsent_chains &= ~sent;
      end
      tracker.prev_frame_number = it.frame_number;
      if (req != tracker.prev_targets) begin
        r.targets_changed = 1'b1;
        tracker.prev_targets = req;
        chains = '0;
        for (c = 0; c < MASK_W; c++) begin
          idx = structure.target_chain_map[IDX_W*c +: IDX_W];
          if (c < nt && req[c] && idx < nc) begin
            chains[idx] = 1'b1;
          end
        end
        tracker.live_chains = chains;
        tracker.unsent_chains = (chains == '0) ? FORCED_CHAIN_MASK : chains;
      end
      r.current_targets = tracker.prev_targets;
      r.current_chains = tracker.live_chains;
      r.pending_chains = tracker.unsent_chains;
      expected_masks.push_back(r);
    endfunction

    function void check_result(input result_t got);
      result_t want;
      if (expected_masks.size() == 0) begin
        $error("Result arrived with no request outstanding.");
        errors++;
        return;
      end
      want = expected_masks.pop_front();
      if (got.current_targets !== want.current_targets) begin
        $error("current_targets: expected %h, actual %h",
               want.current_targets, got.current_targets);
        errors++;
      end
      if (got.current_chains !== want.current_chains) begin
        $error("current_chains: expected %h, actual %h",
               want.current_chains, got.current_chains);
        errors++;
      end
      if (got.pending_chains !== want.pending_chains) begin
        $error("pending_chains: expected %h, actual %h",
               want.pending_chains, got.pending_chains);
        errors++;
      end
      if (got.targets_changed !== want.targets_changed) begin
        $error("targets_changed: expected %b, actual %b",
               want.targets_changed, got.targets_changed);
        errors++;
      end
    endfunction

    function int pending();
      return expected_masks.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [MASK_W-1:0]     in_active_targets = '0;
  logic                  in_key_frame = 1'b0;
  logic [FRAME_W-1:0]    in_frame_number = '0;
  logic [63:0]           in_chain_deltas = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [MASK_W-1:0]     out_current_targets;
  logic [MASK_W-1:0]     out_current_chains;
  logic [MASK_W-1:0]     out_pending_chains;
  logic                  out_targets_changed;

  chain_mask_scoreboard sb;
  int                   cycle_count = 0;
  int                   tx_gap_max = 3;
  int                   rx_stall_max = 3;
  int                   stall_cycles = 0;
  int                   hold_cycles = 0;
  logic [FRAME_W-1:0]   last_frame = '0;
  logic [MASK_W-1:0]    last_request = '0;

  active_decode_target_tracker_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_active_targets   (in_active_targets),
    .in_key_frame        (in_key_frame),
    .in_frame_number     (in_frame_number),
    .in_chain_deltas     (in_chain_deltas),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_current_targets (out_current_targets),
    .out_current_chains  (out_current_chains),
    .out_pending_chains  (out_pending_chains),
    .out_targets_changed (out_targets_changed)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("active_decode_target_tracker_unit verification failed");
      $finish;
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else if (stall_cycles > 0) begin
        out_stall <= 1'b1;
        stall_cycles--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result({out_current_targets, out_current_chains, out_pending_chains,
                       out_targets_changed});
      stall_cycles = $urandom_range(0, rx_stall_max);
    end
  end

  task automatic send_frame(input item_t it, input int gap);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_active_targets <= it.active_targets;
    in_key_frame <= it.key_frame;
    in_frame_number <= it.frame_number;
    in_chain_deltas <= it.chain_deltas;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(it);
    last_frame = it.frame_number;
    last_request = it.active_targets;
  endtask

  task automatic send_item(input logic [MASK_W-1:0] active, input logic key,
                           input logic [FRAME_W-1:0] frame, input logic [63:0] deltas);
    item_t it;
    it.active_targets = active;
    it.key_frame = key;
    it.frame_number = frame;
    it.chain_deltas = deltas;
    send_frame(it, $urandom_range(0, tx_gap_max));
  endtask

  task automatic send_random(input int gap);
    item_t              it;
    logic [FRAME_W-1:0] step;
    int                 roll;
    roll = $urandom_range(0, 99);
    it.key_frame = ($urandom_range(0, 99) < 6);
    if (roll < 10) begin
      it.frame_number = FRAME_W'($urandom);
    end else if (roll < 15) begin
      it.frame_number = last_frame + FRAME_W'($urandom_range(256, 4000));
    end else begin
      it.frame_number = last_frame + FRAME_W'($urandom_range(1, 6));
    end
    step = it.frame_number - last_frame;
    if (roll < 20) begin
      it.chain_deltas = {$urandom, $urandom};
    end else begin
      for (int c = 0; c < MASK_W; c++) begin
        if ($urandom_range(0, 1) == 1 && step < 16'd256) begin
          it.chain_deltas[DELTA_W*c +: DELTA_W] = step[DELTA_W-1:0];
        end else begin
          it.chain_deltas[DELTA_W*c +: DELTA_W] = DELTA_W'($urandom_range(0, 8));
        end
      end
    end
    if ($urandom_range(0, 99) < 20) begin
      it.active_targets = MASK_W'($urandom);
    end else begin
      it.active_targets = last_request;
    end
    send_frame(it, gap);
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.note_config(idx, data);
  endtask

  task automatic set_structure(input logic [IDX_W-1:0] nt, input logic [IDX_W-1:0] nc,
                               input logic [CFG_DATA_W-1:0] map);
    wait_for_results();
    write_reg(CFG_NUM_TARGETS, {28'($urandom), nt});
    write_reg(CFG_NUM_CHAIN_COUNT, {28'($urandom), nc});
    write_reg(CFG_TARGET_CHAIN_MAP, map);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [CFG_DATA_W-1:0] random_map();
    logic [CFG_DATA_W-1:0] m;
    for (int i = 0; i < MASK_W; i++) begin
      m[IDX_W*i +: IDX_W] = IDX_W'($urandom_range(0, 9));
    end
    return m;
  endfunction

  task automatic run_phase(input logic [IDX_W-1:0] nt, input logic [IDX_W-1:0] nc,
                           input logic [CFG_DATA_W-1:0] map, input int count,
                           input int gap_max, input int stall_max, input bit with_hold);
    set_structure(nt, nc, map);
    tx_gap_max = gap_max;
    rx_stall_max = stall_max;
    for (int n = 0; n < count; n++) begin
      if (with_hold && n == count / 2) begin
        hold_cycles = 70;
        repeat (24) send_random(0);
      end
      send_random($urandom_range(0, tx_gap_max));
    end
  endtask

  initial begin
    sb = new();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    send_item(8'hFF, 1'b0, 16'h0001, 64'h0);
    send_item(8'hFF, 1'b1, 16'h0002, 64'h0);

    set_structure(4'd15, 4'd15, 32'h7654_3210);
    send_item(8'hFF, 1'b1, 16'd10, 64'h0);
    send_item(8'hFF, 1'b0, 16'd11, 64'h0000_0000_0100_0001);
    send_item(8'h0F, 1'b0, 16'd12, 64'h0);
    send_item(8'h0F, 1'b0, 16'd14, 64'h0505_0505_0502_0502);
    send_item(8'h0F, 1'b0, 16'd314, 64'h2C2C_2C2C_2C2C_2C2C);
    send_item(8'h0F, 1'b0, 16'hFFFE, 64'h0);
    send_item(8'h0F, 1'b0, 16'h0001, 64'h0303_0303_0303_0303);
    send_item(8'h00, 1'b0, 16'h0002, 64'h0);
    send_item(8'h80, 1'b0, 16'h0101, 64'hFF00_0000_0000_0000);
    send_item(8'h80, 1'b0, 16'h0200, 64'hFF00_0000_0000_0000);
    send_item(8'h33, 1'b1, 16'h0201, 64'hFFFF_FFFF_FFFF_FFFF);

    set_structure(4'd3, 4'd1, 32'hFFFF_F100);
    send_item(8'h00, 1'b1, 16'h1000, 64'h0);
    send_item(8'hFF, 1'b0, 16'h1001, 64'h0);
    send_item(8'hF8, 1'b0, 16'h1002, 64'h0101_0101_0101_0101);

    set_structure(4'd8, 4'd8, 32'hFFFF_FFFF);
    send_item(8'hAA, 1'b0, 16'h8000, 64'h0);
    send_item(8'h55, 1'b1, 16'h8001, 64'h0);

    set_structure(4'd8, 4'd0, 32'h0000_0000);
    send_item(8'h01, 1'b0, 16'h8002, 64'h0101_0101_0101_0101);
    send_item(8'h01, 1'b1, 16'h8003, 64'h0);

    run_phase(4'd8, 4'd8, 32'h7654_3210, 260, 14, 14, 1'b1);
    run_phase(4'd15, 4'd15, random_map(), 200, 0, 0, 1'b0);
    run_phase(4'd0, 4'd0, 32'hFFFF_FFFF, 80, 5, 14, 1'b0);
    run_phase(4'd3, 4'd2, random_map(), 180, 14, 0, 1'b0);
    run_phase(4'd8, 4'd8, 32'h0000_0000, 120, 14, 14, 1'b0);
    run_phase(4'd1, 4'd1, random_map(), 80, 3, 3, 1'b0);
    repeat (5) begin
      run_phase(IDX_W'($urandom_range(0, 15)), IDX_W'($urandom_range(0, 15)), random_map(),
                100, ($urandom_range(0, 1) == 1) ? 14 : 0,
                ($urandom_range(0, 1) == 1) ? 14 : 0, 1'b0);
    end

    wait_for_results();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("active_decode_target_tracker_unit verification clean");
    end else begin
      $display("active_decode_target_tracker_unit verification failed");
    end
    $finish;
  end

endmodule
